>>> src/obot_pkg.sv
// shared constants for the oriented box overlap test
// no dependencies; imported by the top level and its checker
package obot_pkg;

    // coordinate width, signed q12.4 at the default
    localparam int CoordW = 16;

    // number of coordinates per rectangle (x and y of four corners)
    localparam int NumCoord = 8;

    // derived arithmetic widths, all exact
    localparam int AxisW = CoordW + 1;
    localparam int ProdW = CoordW + AxisW;
    localparam int DotW  = ProdW + 1;

    // stream word widths
    localparam int InTdataW  = ((NumCoord * CoordW + 7) / 8) * 8;
    localparam int InTuserW  = 1;
    localparam int OutTdataW = 8;

    // function codes carried in the input tuser
    localparam logic FuncLoad = 1'b0;
    localparam logic FuncTest = 1'b1;

endpackage

>>> src/oriented_box_overlap_test_top.sv
// oriented box overlap test by separating axes, three register stages
// depends on obot_pkg
//
// an accepted test word passes stage 1, stage 2 and the output register to o_m_tvalid
// throughput: one word per cycle; stages stall only from o_m_tready back-pressure
// load words update the reference at once and give no result
// reset: synchronous active-low i_rst_n clears the valid flags and the reference corners
// tests issued before any load run against all corners at the origin
module oriented_box_overlap_test_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    //        corner3_x, corner3_y, each signed, lowest bits first
    input  logic [obot_pkg::InTdataW-1:0]   i_s_tdata,
    // tuser: func (0 load reference, 1 test)
    input  logic [obot_pkg::InTuserW-1:0]   i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: overlap in bit 0, zero padding above
    output logic [obot_pkg::OutTdataW-1:0]  o_m_tdata
);
    import obot_pkg::*;

    // reference rectangle, order x0 y0 x1 y1 x2 y2 x3 y3
    logic signed [CoordW-1:0] r_ref [NumCoord];

    // stage 1: snapshot of reference and candidate for one test word
    logic                     r_s1_valid;
    logic signed [CoordW-1:0] r_s1_ref  [NumCoord];
    logic signed [CoordW-1:0] r_s1_cand [NumCoord];

    // stage 2: projections, index [axis][rectangle 0 ref / 1 cand][corner]
    logic                     r_s2_valid;
    logic signed [DotW-1:0]   r_s2_dot [4][2][4];
    logic signed [DotW-1:0]   n_s2_dot [4][2][4];

    // output stage
    logic                     r_out_valid;
    logic                     r_overlap;
    logic                     n_overlap;

    logic en_out, en_s2, en_s1;
    logic accept;

    logic signed [AxisW-1:0]  ax [4];
    logic signed [AxisW-1:0]  ay [4];

    // a stage moves on when the stage after it is empty or moving
    assign en_out     = !r_out_valid || i_m_tready;
    assign en_s2      = !r_s2_valid || en_out;
    assign en_s1      = !r_s1_valid || en_s2;
    assign o_s_tready = en_s1;
    assign accept     = i_s_tvalid && en_s1;

    // reference store, written by load words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumCoord; k++) begin
                r_ref[k] <= '0;
            end
        end else if (accept && (i_s_tuser[0] == FuncLoad)) begin
            for (int k = 0; k < NumCoord; k++) begin
                r_ref[k] <= i_s_tdata[k*CoordW +: CoordW];
            end
        end
    end

    // stage 1 captures the current reference with the candidate, so a later
    // load cannot disturb a test already in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= accept && (i_s_tuser[0] == FuncTest);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_s_tuser[0] == FuncTest)) begin
            for (int k = 0; k < NumCoord; k++) begin
                r_s1_ref[k]  <= r_ref[k];
                r_s1_cand[k] <= i_s_tdata[k*CoordW +: CoordW];
            end
        end
    end

    // the four axes: two reference edges, two candidate edges
    always_comb begin
        ax[0] = AxisW'(r_s1_ref[2])  - AxisW'(r_s1_ref[0]);
        ay[0] = AxisW'(r_s1_ref[3])  - AxisW'(r_s1_ref[1]);
        ax[1] = AxisW'(r_s1_ref[2])  - AxisW'(r_s1_ref[4]);
        ay[1] = AxisW'(r_s1_ref[3])  - AxisW'(r_s1_ref[5]);
        ax[2] = AxisW'(r_s1_cand[0]) - AxisW'(r_s1_cand[6]);
        ay[2] = AxisW'(r_s1_cand[1]) - AxisW'(r_s1_cand[7]);
        ax[3] = AxisW'(r_s1_cand[0]) - AxisW'(r_s1_cand[2]);
        ay[3] = AxisW'(r_s1_cand[1]) - AxisW'(r_s1_cand[3]);
    end

    // dot products of every corner with every axis, exact width
    always_comb begin
        logic signed [ProdW-1:0] px, py;
        logic signed [CoordW-1:0] cx, cy;
        px = '0;
        py = '0;
        cx = '0;
        cy = '0;
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < 4; k++) begin
                    cx = (b == 0) ? r_s1_ref[2*k]   : r_s1_cand[2*k];
                    cy = (b == 0) ? r_s1_ref[2*k+1] : r_s1_cand[2*k+1];
                    px = ProdW'(cx) * ProdW'(ax[a]);
                    py = ProdW'(cy) * ProdW'(ay[a]);
                    n_s2_dot[a][b][k] = DotW'(px) + DotW'(py);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_dot <= n_s2_dot;
        end
    end

    // interval per rectangle and axis; any gap separates the boxes
    always_comb begin
        logic signed [DotW-1:0] lo [2];
        logic signed [DotW-1:0] hi [2];
        n_overlap = 1'b1;
        for (int b = 0; b < 2; b++) begin
            lo[b] = '0;
            hi[b] = '0;
        end
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 2; b++) begin
                lo[b] = r_s2_dot[a][b][0];
                hi[b] = r_s2_dot[a][b][0];
                for (int k = 1; k < 4; k++) begin
                    if (r_s2_dot[a][b][k] < lo[b]) begin
                        lo[b] = r_s2_dot[a][b][k];
                    end
                    if (r_s2_dot[a][b][k] > hi[b]) begin
                        hi[b] = r_s2_dot[a][b][k];
                    end
                end
            end
            // touching intervals still count as overlap
            if ((hi[0] < lo[1]) || (hi[1] < lo[0])) begin
                n_overlap = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_overlap <= n_overlap;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutTdataW-1){1'b0}}, r_overlap};

endmodule

>>> src/obot_checker.sv
// port-level checks for the oriented box overlap test, with its bind
// depends on obot_pkg and oriented_box_overlap_test_top
module obot_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            o_s_tready,
    input  logic [obot_pkg::InTdataW-1:0]   i_s_tdata,
    input  logic [obot_pkg::InTuserW-1:0]   i_s_tuser,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [obot_pkg::OutTdataW-1:0]  o_m_tdata
);
    import obot_pkg::*;

    // the pipeline only refuses input when the result register is blocked
    a_ready_only_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready)
    ) else $error("input stalled without output back-pressure");

    // a blocked result keeps its value
    a_hold_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata))
    ) else $error("result changed while stalled");

    // reset empties the pipeline and opens the input
    a_reset_clears: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready)
    ) else $error("pipeline not empty after reset");

    // padding above the overlap flag stays zero
    a_pad_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OutTdataW-1:1] == '0)
    ) else $error("result padding not zero");

endmodule

bind oriented_box_overlap_test_top obot_checker u_obot_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
